// ===== rtl/core/tct_pkg.sv =====
// ----------------------------------------------------------------------------
// Two-camera touch triangulator package
// Shared widths, register indexes, event codes, payload types and states.
// ----------------------------------------------------------------------------
package tct_pkg;

    localparam int COORD_WIDTH   = 16;
    localparam int TIME_WIDTH    = 32;
    localparam int COLUMN_WIDTH  = 12;
    localparam int CFG_WIDTH     = 16;
    localparam int CFG_IDX_WIDTH = 3;

    localparam int ANG_PI       = 51472;
    localparam int ANG_HALF_PI  = 25736;
    localparam int ANG_TWO_PI   = 102944;
    localparam int TRIG_K       = 636750;
    localparam int CORDIC_STEPS = 15;

    localparam logic [11:0] RST_SENSOR_WIDTH = 12'd1280;
    localparam logic [13:0] RST_BASELINE     = 14'd2681;
    localparam logic [12:0] RST_OFFSET_X     = 13'd408;
    localparam logic [12:0] RST_OFFSET_Y     = 13'd186;
    localparam logic [15:0] RST_FOV          = 16'd18301;
    localparam logic [15:0] RST_DWELL_MS     = 16'd1000;
    localparam logic [7:0]  RST_CLICK_RADIUS = 8'd10;

    localparam logic [CFG_IDX_WIDTH-1:0] CFG_SENSOR_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_BASELINE      = 3'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_OFFSET_X      = 3'd2;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_OFFSET_Y      = 3'd3;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_FIELD_OF_VIEW = 3'd4;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_DWELL_MS      = 3'd5;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_CLICK_RADIUS  = 3'd6;

    localparam logic [1:0] EV_NONE    = 2'd0;
    localparam logic [1:0] EV_MOVE    = 2'd1;
    localparam logic [1:0] EV_PRESS   = 2'd2;
    localparam logic [1:0] EV_RELEASE = 2'd3;

    typedef struct packed {
        logic                    blob_a_valid;
        logic [COLUMN_WIDTH-1:0] blob_a_col;
        logic                    blob_b_valid;
        logic [COLUMN_WIDTH-1:0] blob_b_col;
        logic [TIME_WIDTH-1:0]   now_ms;
    } t_in_item;

    typedef struct packed {
        logic [1:0]                    event_kind;
        logic                          pressed;
        logic signed [COORD_WIDTH-1:0] touch_x;
        logic signed [COORD_WIDTH-1:0] touch_y;
    } t_out_item;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_PREP,
        ST_ANGLES,
        ST_LOADANG,
        ST_REDUCE,
        ST_FOLD,
        ST_ROTATE,
        ST_STORE,
        ST_NUMER,
        ST_DIVIDE,
        ST_CLAMP,
        ST_MULT,
        ST_OFFSET,
        ST_ROUND,
        ST_DIST,
        ST_DWELL,
        ST_DONE
    } t_state;

    function automatic logic [13:0] atan_entry(input logic [3:0] idx);
        logic [13:0] v;
        case (idx)
            4'd0:    v = 14'd12868;
            4'd1:    v = 14'd7596;
            4'd2:    v = 14'd4014;
            4'd3:    v = 14'd2037;
            4'd4:    v = 14'd1023;
            4'd5:    v = 14'd512;
            4'd6:    v = 14'd256;
            4'd7:    v = 14'd128;
            4'd8:    v = 14'd64;
            4'd9:    v = 14'd32;
            4'd10:   v = 14'd16;
            4'd11:   v = 14'd8;
            4'd12:   v = 14'd4;
            4'd13:   v = 14'd2;
            4'd14:   v = 14'd1;
            default: v = 14'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/core/tct_in_if.sv =====
// ----------------------------------------------------------------------------
// Frame request channel
// Valid/ready channel that carries one camera frame request.
// ----------------------------------------------------------------------------
interface tct_in_if import tct_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/tct_out_if.sv =====
// ----------------------------------------------------------------------------
// Touch result channel
// Valid/ready channel that carries one touch event request.
// ----------------------------------------------------------------------------
interface tct_out_if import tct_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/two_camera_touch_triangulator_top.sv =====
// ----------------------------------------------------------------------------
// Two-camera touch triangulator
// Triangulates a touch point from two corner cameras and turns dwell into a
// button press, with one shared CORDIC, serial dividers and a serial multiply.
// ----------------------------------------------------------------------------
// A frame with both blobs passes through the shared CORDIC (one atan and
// three sine/cosine passes), the 44-bit serial divide and the 26-bit serial
// multiply. A frame with a blob missing goes straight from idle to done.
// Throughput: one request at a time; the next is taken after the result leaves
// the working state. Synchronous reset restores register defaults and a
// released button with no anchor.
module two_camera_touch_triangulator_top import tct_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_WIDTH-1:0] i_cfg_idx,
    input  logic [CFG_WIDTH-1:0]     i_cfg_data,
    tct_in_if.sink                   i_in,
    tct_out_if.source                o_out
);

    t_state r_state, n_state;

    logic [11:0] r_sw;
    logic [13:0] r_bl;
    logic [12:0] r_ox, r_oy;
    logic [15:0] r_fov, r_dwell;
    logic [7:0]  r_rad;

    logic                          r_held;
    logic signed [COORD_WIDTH-1:0] r_last_x, r_last_y, r_anc_x, r_anc_y;
    logic [TIME_WIDTH-1:0]         r_anc_t, r_now;
    t_out_item                     r_res, r_out;
    logic                          r_out_valid;

    logic [5:0]  r_step;
    logic        r_atan_run;
    logic [27:0] r_qa, r_qb;
    logic [11:0] r_ra, r_rb;
    logic        r_qb_neg;
    logic signed [35:0] r_cx, r_cy;
    logic signed [19:0] r_cz;
    logic signed [31:0] r_ta, r_tb, r_tp;
    logic [1:0]  r_sel;
    logic [31:0] r_red;
    logic        r_red_neg, r_neg;
    logic signed [21:0] r_sa, r_cosa, r_sb, r_sp;
    logic [43:0] r_dq;
    logic [20:0] r_dr, r_dvs;
    logic        r_num_zero, r_q_neg;
    logic [25:0] r_db;
    logic        r_db_neg;
    logic signed [49:0] r_acc_x, r_acc_y;
    logic signed [COORD_WIDTH-1:0] r_px, r_py;
    logic [17:0] r_sqx, r_sqy, r_r1sq;
    logic        r_big;

    logic accept, out_free, blobs_ok;
    assign accept   = i_in.valid && i_in.ready;
    assign out_free = !r_out_valid || o_out.ready;
    assign blobs_ok = i_in.data.blob_a_valid && i_in.data.blob_b_valid;
    assign i_in.ready  = (r_state == ST_IDLE);
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    // Request-time setup values.
    logic signed [15:0] w_xs, w_xv, w_yv;
    logic signed [12:0] w_diffb;
    logic [11:0]        w_diff_mag;
    logic [27:0]        w_prod_a, w_prod_b;
    assign w_xs = $signed({2'b00, r_bl}) - $signed({3'b000, r_ox});
    assign w_xv = w_xs[15] ? -w_xs : w_xs;
    assign w_yv = w_xs[15] ? -$signed({3'b000, r_oy}) : $signed({3'b000, r_oy});
    assign w_diffb = $signed({1'b0, r_sw}) - $signed({1'b0, i_in.data.blob_b_col});
    assign w_diff_mag = w_diffb[12] ? 12'(-w_diffb) : 12'(w_diffb);
    assign w_prod_a = 28'(i_in.data.blob_a_col) * 28'(r_fov);
    assign w_prod_b = 28'(w_diff_mag) * 28'(r_fov);

    // Column dividers.
    logic [12:0] w_ta, w_tb;
    logic        w_gea, w_geb;
    assign w_ta  = {r_ra, r_qa[27]};
    assign w_tb  = {r_rb, r_qb[27]};
    assign w_gea = w_ta >= {1'b0, r_sw};
    assign w_geb = w_tb >= {1'b0, r_sw};

    // Shared CORDIC step.
    logic signed [35:0] w_sx, w_sy;
    logic signed [19:0] w_atan;
    logic               w_up;
    assign w_sx   = r_cx >>> r_step[3:0];
    assign w_sy   = r_cy >>> r_step[3:0];
    assign w_atan = $signed({6'b000000, atan_entry(r_step[3:0])});
    assign w_up   = (r_state == ST_ROTATE) ? !r_cz[19] : r_cy[35];

    // Angle formation.
    logic signed [31:0] w_ct, w_qa_t, w_qb_t, w_ang_a, w_ang_b, w_cur;
    assign w_ct    = 32'(r_cz);
    assign w_qa_t  = (r_sw == 12'd0) ? 32'sd0 : $signed({4'b0000, r_qa});
    assign w_qb_t  = (r_sw == 12'd0) ? 32'sd0 :
                     (r_qb_neg ? -$signed({4'b0000, r_qb}) : $signed({4'b0000, r_qb}));
    assign w_ang_a = w_ct + w_qa_t;
    assign w_ang_b = w_ct + w_qb_t;
    assign w_cur   = (r_sel == 2'd0) ? r_ta : ((r_sel == 2'd1) ? r_tb : r_tp);

    logic [31:0] w_turns;
    assign w_turns = 32'(ANG_TWO_PI) << r_step[3:0];

    logic signed [18:0] w_a0, w_a1, w_a2;
    logic               w_fneg;
    always_comb begin
        w_a0 = r_red_neg ? -$signed({1'b0, r_red[17:0]}) : $signed({1'b0, r_red[17:0]});
        w_a1 = w_a0;
        if (w_a0 > ANG_PI) begin
            w_a1 = w_a0 - 19'(ANG_TWO_PI);
        end else if (w_a0 < -ANG_PI) begin
            w_a1 = w_a0 + 19'(ANG_TWO_PI);
        end
        w_a2   = w_a1;
        w_fneg = 1'b0;
        if (w_a1 > ANG_HALF_PI) begin
            w_a2   = w_a1 - 19'(ANG_PI);
            w_fneg = 1'b1;
        end else if (w_a1 < -ANG_HALF_PI) begin
            w_a2   = w_a1 + 19'(ANG_PI);
            w_fneg = 1'b1;
        end
    end

    logic signed [21:0] w_sin, w_cos;
    assign w_sin = 22'(r_neg ? -r_cy : r_cy);
    assign w_cos = 22'(r_neg ? -r_cx : r_cx);

    logic signed [36:0] w_num;
    logic [35:0]        w_num_mag;
    assign w_num     = $signed({1'b0, r_bl}) * r_sb;
    assign w_num_mag = w_num[36] ? 36'(-w_num) : 36'(w_num);

    logic [21:0] w_dt;
    logic        w_dge;
    assign w_dt  = {r_dr, r_dq[43]};
    assign w_dge = w_dt >= {1'b0, r_dvs};

    logic signed [49:0] w_rx_s, w_ry_s;
    logic signed [21:0] w_rx, w_ry;
    assign w_rx_s = (r_acc_x + (r_acc_x[49] ? 50'sd268435455 : 50'sd0)) >>> 28;
    assign w_ry_s = (r_acc_y + (r_acc_y[49] ? 50'sd268435455 : 50'sd0)) >>> 28;
    assign w_rx   = 22'(w_rx_s);
    assign w_ry   = 22'(w_ry_s);

    logic signed [16:0] w_dx, w_dy;
    logic [16:0]        w_adx, w_ady;
    logic [8:0]         w_r1;
    assign w_dx  = 17'(r_px) - 17'(r_anc_x);
    assign w_dy  = 17'(r_py) - 17'(r_anc_y);
    assign w_adx = w_dx[16] ? 17'(-w_dx) : 17'(w_dx);
    assign w_ady = w_dy[16] ? 17'(-w_dy) : 17'(w_dy);
    assign w_r1  = 9'(r_rad) + 9'd1;

    logic                  w_far, w_upd;
    logic [TIME_WIDTH-1:0] w_anc_t, w_elapsed;
    assign w_far     = r_big || ((19'(r_sqx) + 19'(r_sqy)) >= 19'(r_r1sq));
    assign w_upd     = (r_anc_t == '0) || w_far;
    assign w_anc_t   = w_upd ? r_now : r_anc_t;
    assign w_elapsed = r_now - w_anc_t;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = blobs_ok ? ST_PREP : ST_DONE;
                end
            end
            ST_PREP:    if (r_step == 6'd27) n_state = ST_ANGLES;
            ST_ANGLES:  n_state = ST_LOADANG;
            ST_LOADANG: n_state = ST_REDUCE;
            ST_REDUCE:  if (r_step == 6'd0) n_state = ST_FOLD;
            ST_FOLD:    n_state = ST_ROTATE;
            ST_ROTATE:  if (r_step == 6'd14) n_state = ST_STORE;
            ST_STORE:   n_state = (r_sel == 2'd2) ? ST_NUMER : ST_LOADANG;
            ST_NUMER:   n_state = ST_DIVIDE;
            ST_DIVIDE:  if (r_step == 6'd43) n_state = ST_CLAMP;
            ST_CLAMP:   n_state = ST_MULT;
            ST_MULT:    if (r_step == 6'd25) n_state = ST_OFFSET;
            ST_OFFSET:  n_state = ST_ROUND;
            ST_ROUND:   n_state = ST_DIST;
            ST_DIST:    n_state = ST_DWELL;
            ST_DWELL:   n_state = ST_DONE;
            ST_DONE:    if (out_free) n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    // Configuration, touch state and the result valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sw        <= RST_SENSOR_WIDTH;
            r_bl        <= RST_BASELINE;
            r_ox        <= RST_OFFSET_X;
            r_oy        <= RST_OFFSET_Y;
            r_fov       <= RST_FOV;
            r_dwell     <= RST_DWELL_MS;
            r_rad       <= RST_CLICK_RADIUS;
            r_held      <= 1'b0;
            r_last_x    <= '0;
            r_last_y    <= '0;
            r_anc_x     <= '0;
            r_anc_y     <= '0;
            r_anc_t     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_SENSOR_WIDTH:  r_sw    <= i_cfg_data[11:0];
                    CFG_BASELINE:      r_bl    <= i_cfg_data[13:0];
                    CFG_OFFSET_X:      r_ox    <= i_cfg_data[12:0];
                    CFG_OFFSET_Y:      r_oy    <= i_cfg_data[12:0];
                    CFG_FIELD_OF_VIEW: r_fov   <= i_cfg_data[15:0];
                    CFG_DWELL_MS:      r_dwell <= i_cfg_data[15:0];
                    CFG_CLICK_RADIUS:  r_rad   <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (accept && !blobs_ok && r_held) begin
                r_held  <= 1'b0;
                r_anc_t <= '0;
            end
            if (r_state == ST_DWELL) begin
                r_last_x <= r_px;
                r_last_y <= r_py;
                if (!r_held) begin
                    if (w_upd) begin
                        r_anc_t <= r_now;
                        r_anc_x <= r_px;
                        r_anc_y <= r_py;
                    end
                    if (w_elapsed > TIME_WIDTH'(r_dwell)) begin
                        r_held <= 1'b1;
                    end
                end
            end
            if (r_state == ST_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Arithmetic datapath.
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    r_now  <= i_in.data.now_ms;
                    r_step <= '0;
                    r_res.event_kind <= r_held ? EV_RELEASE : EV_NONE;
                    r_res.pressed    <= 1'b0;
                    r_res.touch_x    <= r_last_x;
                    r_res.touch_y    <= r_last_y;
                    r_qa     <= w_prod_a;
                    r_qb     <= w_prod_b;
                    r_ra     <= '0;
                    r_rb     <= '0;
                    r_qb_neg <= w_diffb[12];
                    r_cx     <= 36'(w_xv) <<< 16;
                    r_cy     <= 36'(w_yv) <<< 16;
                    r_atan_run <= 1'b0;
                    if (r_oy == 13'd0) begin
                        r_cz <= w_xs[15] ? 20'(ANG_PI) : 20'sd0;
                    end else if (w_xs == 16'sd0) begin
                        r_cz <= 20'(ANG_HALF_PI);
                    end else begin
                        r_cz       <= w_xs[15] ? 20'(ANG_PI) : 20'sd0;
                        r_atan_run <= 1'b1;
                    end
                end
            end
            ST_PREP: begin
                r_step <= r_step + 6'd1;
                r_qa <= {r_qa[26:0], w_gea};
                r_qb <= {r_qb[26:0], w_geb};
                r_ra <= w_gea ? 12'(w_ta - {1'b0, r_sw}) : w_ta[11:0];
                r_rb <= w_geb ? 12'(w_tb - {1'b0, r_sw}) : w_tb[11:0];
                if (r_atan_run && r_step < 6'(CORDIC_STEPS)) begin
                    if (w_up) begin
                        r_cx <= r_cx - w_sy;
                        r_cy <= r_cy + w_sx;
                        r_cz <= r_cz - w_atan;
                    end else begin
                        r_cx <= r_cx + w_sy;
                        r_cy <= r_cy - w_sx;
                        r_cz <= r_cz + w_atan;
                    end
                end
            end
            ST_ANGLES: begin
                r_ta  <= w_ang_a;
                r_tb  <= w_ang_b;
                r_tp  <= 32'(ANG_PI) - w_ang_a - w_ang_b;
                r_sel <= 2'd0;
            end
            ST_LOADANG: begin
                r_red     <= w_cur[31] ? 32'(-w_cur) : 32'(w_cur);
                r_red_neg <= w_cur[31];
                r_step    <= 6'd14;
            end
            ST_REDUCE: begin
                if (r_red >= w_turns) begin
                    r_red <= r_red - w_turns;
                end
                r_step <= r_step - 6'd1;
            end
            ST_FOLD: begin
                r_cx   <= 36'(TRIG_K);
                r_cy   <= '0;
                r_cz   <= 20'(w_a2);
                r_neg  <= w_fneg;
                r_step <= '0;
            end
            ST_ROTATE: begin
                r_step <= r_step + 6'd1;
                if (w_up) begin
                    r_cx <= r_cx - w_sy;
                    r_cy <= r_cy + w_sx;
                    r_cz <= r_cz - w_atan;
                end else begin
                    r_cx <= r_cx + w_sy;
                    r_cy <= r_cy - w_sx;
                    r_cz <= r_cz + w_atan;
                end
            end
            ST_STORE: begin
                case (r_sel)
                    2'd0: begin
                        r_sa   <= w_sin;
                        r_cosa <= w_cos;
                    end
                    2'd1:    r_sb <= w_sin;
                    default: r_sp <= w_sin;
                endcase
                r_sel <= r_sel + 2'd1;
            end
            ST_NUMER: begin
                r_dq       <= {w_num_mag, 8'h00};
                r_num_zero <= (w_num_mag == 36'd0);
                r_q_neg    <= w_num[36] ^ r_sp[21];
                r_dvs      <= r_sp[21] ? 21'(-r_sp) : 21'(r_sp);
                r_dr       <= '0;
                r_step     <= '0;
            end
            ST_DIVIDE: begin
                r_step <= r_step + 6'd1;
                r_dq   <= {r_dq[42:0], w_dge};
                r_dr   <= w_dge ? 21'(w_dt - {1'b0, r_dvs}) : w_dt[20:0];
            end
            ST_CLAMP: begin
                if (r_num_zero) begin
                    r_db <= '0;
                end else if (r_dq > 44'h2000000) begin
                    r_db <= 26'h2000000;
                end else begin
                    r_db <= r_dq[25:0];
                end
                r_db_neg <= r_q_neg;
                r_acc_x  <= '0;
                r_acc_y  <= '0;
                r_step   <= '0;
            end
            ST_MULT: begin
                r_step  <= r_step + 6'd1;
                r_db    <= {r_db[24:0], 1'b0};
                r_acc_x <= (r_acc_x <<< 1) + (r_db[25] ? 50'(r_cosa) : 50'sd0);
                r_acc_y <= (r_acc_y <<< 1) + (r_db[25] ? 50'(r_sa) : 50'sd0);
            end
            ST_OFFSET: begin
                r_acc_x <= (r_db_neg ? -r_acc_x : r_acc_x) - ($signed({37'd0, r_ox}) <<< 28);
                r_acc_y <= (r_db_neg ? -r_acc_y : r_acc_y) - ($signed({37'd0, r_oy}) <<< 28);
            end
            ST_ROUND: begin
                r_px <= (w_rx > 22'sd32767) ? 16'sh7FFF :
                        ((w_rx < -22'sd32768) ? 16'sh8000 : 16'(w_rx));
                r_py <= (w_ry > 22'sd32767) ? 16'sh7FFF :
                        ((w_ry < -22'sd32768) ? 16'sh8000 : 16'(w_ry));
            end
            ST_DIST: begin
                r_big  <= (w_adx > 17'd256) || (w_ady > 17'd256);
                r_sqx  <= 18'(w_adx[8:0]) * 18'(w_adx[8:0]);
                r_sqy  <= 18'(w_ady[8:0]) * 18'(w_ady[8:0]);
                r_r1sq <= 18'(w_r1) * 18'(w_r1);
            end
            ST_DWELL: begin
                r_res.touch_x <= r_px;
                r_res.touch_y <= r_py;
                if (r_held) begin
                    r_res.event_kind <= EV_MOVE;
                    r_res.pressed    <= 1'b1;
                end else if (w_elapsed > TIME_WIDTH'(r_dwell)) begin
                    r_res.event_kind <= EV_PRESS;
                    r_res.pressed    <= 1'b1;
                end else begin
                    r_res.event_kind <= EV_MOVE;
                    r_res.pressed    <= 1'b0;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    r_out <= r_res;
                end
            end
            default: ;
        endcase
    end

endmodule

// ===== dv/two_camera_touch_triangulator_top_tb.sv =====
// ----------------------------------------------------------------------------
// Two-camera touch triangulator testbench
// Drives camera frame requests through the valid/ready channel, predicts each
// touch event with an independent integer model of the angle, triangulation
// and dwell logic, and compares every result field. Covers register extremes,
// missing blobs, press and release, time wrap and back-pressure.
// ----------------------------------------------------------------------------
module two_camera_touch_triangulator_top_tb;
    import tct_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int LONG_HOLD      = 400;
    localparam longint ATAN_STEP [CORDIC_STEPS] = '{
        12868, 7596, 4014, 2037, 1023, 512, 256, 128, 64, 32, 16, 8, 4, 2, 1
    };

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_cfg_we;
    logic [CFG_IDX_WIDTH-1:0] i_cfg_idx;
    logic [CFG_WIDTH-1:0]     i_cfg_data;

    tct_in_if  frame_ch ();
    tct_out_if touch_ch ();

    two_camera_touch_triangulator_top u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (frame_ch.sink),
        .o_out      (touch_ch.source)
    );

    // Shadow registers and touch state of the predictor.
    longint      sh_width, sh_baseline, sh_offx, sh_offy, sh_fov, sh_dwell, sh_radius;
    bit          tr_held;
    longint      tr_last_x, tr_last_y, tr_anchor_x, tr_anchor_y;
    logic [31:0] tr_anchor_time;

    t_out_item expected_touches[$];
    int        error_count;
    int        frames_sent;
    int        presses_seen;
    int        releases_seen;
    int        idle_cycles;
    int        burst_left;
    bit        no_gaps;
    bit        hold_req;
    int        hold_left;
    int        stall_mode;
    int        stall_timer;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic longint cordic_atan(longint y, longint x);
        longint z, sx, sy;
        z = 0;
        if (y == 0) return (x >= 0) ? 0 : ANG_PI;
        if (x == 0) return (y > 0) ? ANG_HALF_PI : -ANG_HALF_PI;
        if (x < 0) begin
            z = (y >= 0) ? ANG_PI : -ANG_PI;
            x = -x;
            y = -y;
        end
        x = x * 65536;
        y = y * 65536;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            sx = x >>> i;
            sy = y >>> i;
            if (y >= 0) begin
                x = x + sy; y = y - sx; z = z + ATAN_STEP[i];
            end else begin
                x = x - sy; y = y + sx; z = z - ATAN_STEP[i];
            end
        end
        return z;
    endfunction

    task automatic cordic_sincos(input longint ang, output longint s, output longint c);
        longint x, y, sx, sy;
        bit     flip;
        x = TRIG_K;
        y = 0;
        flip = 1'b0;
        ang = ang % ANG_TWO_PI;
        if (ang > ANG_PI) ang = ang - ANG_TWO_PI;
        else if (ang < -ANG_PI) ang = ang + ANG_TWO_PI;
        if (ang > ANG_HALF_PI) begin
            ang = ang - ANG_PI; flip = 1'b1;
        end else if (ang < -ANG_HALF_PI) begin
            ang = ang + ANG_PI; flip = 1'b1;
        end
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            sx = x >>> i;
            sy = y >>> i;
            if (ang >= 0) begin
                x = x - sy; y = y + sx; ang = ang - ATAN_STEP[i];
            end else begin
                x = x + sy; y = y - sx; ang = ang + ATAN_STEP[i];
            end
        end
        if (flip) begin
            x = -x; y = -y;
        end
        s = y;
        c = x;
    endtask

    function automatic longint clip_coord(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    task automatic triangulate_frame(input t_in_item f, output t_out_item r);
        longint      ct, ta, tb, tp, sa, ca, sb, cb, sp, cp, num, db, lim, px, py;
        longint      dx, dy, r1;
        bit          far_move;
        logic [31:0] elapsed;
        r.pressed = 1'b0;
        if (!f.blob_a_valid || !f.blob_b_valid) begin
            r.event_kind = EV_NONE;
            if (tr_held) begin
                r.event_kind   = EV_RELEASE;
                tr_held        = 1'b0;
                tr_anchor_time = '0;
            end
            r.touch_x = tr_last_x[15:0];
            r.touch_y = tr_last_y[15:0];
            return;
        end
        ct = cordic_atan(sh_offy, sh_baseline - sh_offx);
        ta = ct;
        tb = ct;
        if (sh_width != 0) begin
            ta = ta + longint'(f.blob_a_col) * sh_fov / sh_width;
            tb = tb + (sh_width - longint'(f.blob_b_col)) * sh_fov / sh_width;
        end
        tp = ANG_PI - ta - tb;
        cordic_sincos(ta, sa, ca);
        cordic_sincos(tb, sb, cb);
        cordic_sincos(tp, sp, cp);
        lim = longint'(1) << (COORD_WIDTH + 9);
        num = sh_baseline * sb * 256;
        if (sp == 0) db = (num > 0) ? lim : ((num < 0) ? -lim : 0);
        else db = num / sp;
        if (db > lim) db = lim;
        if (db < -lim) db = -lim;
        px = clip_coord((ca * db - sh_offx * (longint'(1) << 28)) / (longint'(1) << 28));
        py = clip_coord((sa * db - sh_offy * (longint'(1) << 28)) / (longint'(1) << 28));
        r.event_kind = EV_MOVE;
        if (!tr_held) begin
            dx = px - tr_anchor_x;
            dy = py - tr_anchor_y;
            r1 = sh_radius + 1;
            if (dx < 0) dx = -dx;
            if (dy < 0) dy = -dy;
            if (dx > 256 || dy > 256) far_move = 1'b1;
            else far_move = (dx * dx + dy * dy) >= r1 * r1;
            if (tr_anchor_time == 0 || far_move) begin
                tr_anchor_time = f.now_ms;
                tr_anchor_x    = px;
                tr_anchor_y    = py;
            end
            elapsed = f.now_ms - tr_anchor_time;
            if (longint'(elapsed) > sh_dwell) begin
                tr_held      = 1'b1;
                r.event_kind = EV_PRESS;
            end
        end
        tr_last_x = px;
        tr_last_y = py;
        r.pressed = tr_held;
        r.touch_x = px[15:0];
        r.touch_y = py[15:0];
    endtask

    // Result checker.
    always @(posedge i_clk) begin
        t_out_item want;
        t_out_item got;
        if (i_rst_n && touch_ch.valid && touch_ch.ready) begin
            got = touch_ch.data;
            if (expected_touches.size() == 0) begin
                $display("%0t: unexpected touch result %p", $time, got);
                error_count++;
            end else begin
                want = expected_touches.pop_front();
                if (got.event_kind !== want.event_kind || got.pressed !== want.pressed ||
                        got.touch_x !== want.touch_x || got.touch_y !== want.touch_y) begin
                    $display("%0t: mismatch expected kind=%0d pressed=%0d x=%0d y=%0d",
                             $time, want.event_kind, want.pressed, want.touch_x,
                             want.touch_y);
                    $display("%0t:          actual   kind=%0d pressed=%0d x=%0d y=%0d",
                             $time, got.event_kind, got.pressed, got.touch_x, got.touch_y);
                    error_count++;
                end
                if (got.event_kind == EV_PRESS) presses_seen++;
                if (got.event_kind == EV_RELEASE) releases_seen++;
            end
        end
    end

    // Watchdog on cycles with no request moving on either channel.
    always @(posedge i_clk) begin
        if ((frame_ch.valid && frame_ch.ready) || (touch_ch.valid && touch_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Result receiver with its own stall pattern and an occasional long hold.
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_left = LONG_HOLD;
            hold_req  = 1'b0;
        end
        if (stall_timer == 0) begin
            stall_mode  = int'($urandom_range(0, 2));
            stall_timer = int'($urandom_range(50, 400));
        end else begin
            stall_timer--;
        end
        if (hold_left > 0) begin
            hold_left--;
            touch_ch.ready <= 1'b0;
        end else begin
            case (stall_mode)
                0: touch_ch.ready <= 1'b1;
                1: touch_ch.ready <= 1'($urandom_range(0, 1));
                default: touch_ch.ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    task automatic send_frame(input t_in_item f);
        t_out_item r;
        int        gap;
        gap = 0;
        if (!no_gaps) begin
            if (burst_left == 0) begin
                gap        = int'($urandom_range(1, 20));
                burst_left = int'($urandom_range(1, 30));
            end else begin
                burst_left--;
            end
        end
        if (gap > 0) begin
            @(negedge i_clk);
            frame_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        frame_ch.valid <= 1'b1;
        frame_ch.data  <= f;
        do @(posedge i_clk); while (!frame_ch.ready);
        triangulate_frame(f, r);
        expected_touches.push_back(r);
        frames_sent++;
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        frame_ch.valid <= 1'b0;
        while (expected_touches.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_WIDTH-1:0] idx, input logic [15:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_SENSOR_WIDTH:  sh_width    = val[11:0];
            CFG_BASELINE:      sh_baseline = val[13:0];
            CFG_OFFSET_X:      sh_offx     = val[12:0];
            CFG_OFFSET_Y:      sh_offy     = val[12:0];
            CFG_FIELD_OF_VIEW: sh_fov      = val;
            CFG_DWELL_MS:      sh_dwell    = val;
            CFG_CLICK_RADIUS:  sh_radius   = val[7:0];
            default: ;
        endcase
    endtask

    task automatic write_all_regs(input logic [15:0] sw, input logic [15:0] bl,
                                  input logic [15:0] ox, input logic [15:0] oy,
                                  input logic [15:0] fov, input logic [15:0] dw,
                                  input logic [15:0] rad);
        wait_drained();
        write_reg(CFG_SENSOR_WIDTH, sw);
        write_reg(CFG_BASELINE, bl);
        write_reg(CFG_OFFSET_X, ox);
        write_reg(CFG_OFFSET_Y, oy);
        write_reg(CFG_FIELD_OF_VIEW, fov);
        write_reg(CFG_DWELL_MS, dw);
        write_reg(CFG_CLICK_RADIUS, rad);
    endtask

    function automatic t_in_item make_frame(bit va, int ca, bit vb, int cb, logic [31:0] t);
        t_in_item f;
        f.blob_a_valid = va;
        f.blob_a_col   = ca[11:0];
        f.blob_b_valid = vb;
        f.blob_b_col   = cb[11:0];
        f.now_ms       = t;
        return f;
    endfunction

    function automatic t_in_item noise_frame();
        return make_frame(1'($urandom_range(0, 1)), int'($urandom_range(0, 4095)),
                          1'($urandom_range(0, 1)), int'($urandom_range(0, 4095)),
                          $urandom);
    endfunction

    // A touch that jitters around one spot, then lifts, with random content.
    task automatic touch_gesture(inout logic [31:0] clock_ms, input int col_span);
        int ca, cb, len;
        ca  = int'($urandom_range(0, col_span));
        cb  = int'($urandom_range(0, col_span));
        len = int'($urandom_range(2, 12));
        for (int k = 0; k < len; k++) begin
            clock_ms = clock_ms + $urandom_range(0, 500);
            send_frame(make_frame(1'b1, ca + int'($urandom_range(0, 4)) - 2, 1'b1,
                                  cb + int'($urandom_range(0, 4)) - 2, clock_ms));
        end
        repeat ($urandom_range(1, 2)) begin
            clock_ms = clock_ms + $urandom_range(1, 100);
            send_frame(make_frame(1'($urandom_range(0, 1)), int'($urandom_range(0, 4095)),
                                  1'b0, int'($urandom_range(0, 4095)), clock_ms));
        end
    endtask

    task automatic run_random_frames(input int count, input int col_span);
        logic [31:0] clock_ms;
        int          start;
        clock_ms = $urandom;
        start    = frames_sent;
        while (frames_sent - start < count) begin
            if ($urandom_range(0, 4) == 0) send_frame(noise_frame());
            else touch_gesture(clock_ms, col_span);
        end
    endtask

    task automatic test_directed_extremes();
        send_frame(make_frame(1'b1, 0, 1'b1, 0, 32'd1));
        send_frame(make_frame(1'b1, 4095, 1'b1, 4095, 32'hFFFF_FFFF));
        send_frame(make_frame(1'b1, 640, 1'b1, 640, 32'd0));
        send_frame(make_frame(1'b1, 640, 1'b1, 640, 32'd500));
        send_frame(make_frame(1'b1, 641, 1'b1, 639, 32'd1600));
        send_frame(make_frame(1'b1, 641, 1'b1, 639, 32'd1700));
        send_frame(make_frame(1'b0, 641, 1'b1, 639, 32'd1800));
        send_frame(make_frame(1'b1, 641, 1'b0, 639, 32'd1900));
        send_frame(make_frame(1'b0, 0, 1'b0, 0, 32'd2000));
        send_frame(make_frame(1'b1, 300, 1'b1, 900, 32'hFFFF_FF00));
        send_frame(make_frame(1'b1, 300, 1'b1, 900, 32'h0000_0500));
        send_frame(make_frame(1'b0, 300, 1'b0, 900, 32'h0000_0600));
        send_frame(make_frame(1'b1, 2048, 1'b1, 2047, 32'h8000_0000));
        send_frame(make_frame(1'b1, 4095, 1'b1, 0, 32'h7FFF_FFFF));
    endtask

    task automatic test_zero_width_and_flat_angle();
        write_all_regs(16'd0, 16'd2681, 16'd408, 16'd0, 16'd18301, 16'd0, 16'd10);
        send_frame(make_frame(1'b1, 100, 1'b1, 200, 32'd10));
        send_frame(make_frame(1'b1, 4095, 1'b1, 0, 32'd20));
        send_frame(make_frame(1'b0, 1, 1'b1, 2, 32'd30));
        write_all_regs(16'd1280, 16'd100, 16'd8191, 16'd0, 16'd51472, 16'd5, 16'd0);
        send_frame(make_frame(1'b1, 0, 1'b1, 1280, 32'd40));
        send_frame(make_frame(1'b1, 1280, 1'b1, 0, 32'd50));
        send_frame(make_frame(1'b1, 640, 1'b1, 640, 32'd60));
    endtask

    task automatic test_back_pressure();
        logic [31:0] clock_ms;
        clock_ms = 32'd1000;
        hold_req = 1'b1;
        no_gaps  = 1'b1;
        repeat (6) touch_gesture(clock_ms, 1280);
        no_gaps = 1'b0;
        wait_drained();
        run_random_frames(20, 1280);
        wait_drained();
    endtask

    task automatic test_register_sweep();
        write_all_regs(16'd4095, 16'd16383, 16'd8191, 16'd8191, 16'd51472, 16'd0, 16'd255);
        run_random_frames(200, 4095);
        write_all_regs(16'd16, 16'd1, 16'd0, 16'd0, 16'd0, 16'd65535, 16'd0);
        run_random_frames(100, 16);
        write_all_regs(16'd1280, 16'd2681, 16'd408, 16'd186, 16'd18301, 16'd300, 16'd20);
        run_random_frames(300, 1280);
        write_all_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd200, 16'hFFFF);
        run_random_frames(150, 4095);
        for (int p = 0; p < 4; p++) begin
            write_all_regs(16'($urandom_range(16, 4095)), 16'($urandom_range(1, 16383)),
                           16'($urandom_range(0, 8191)), 16'($urandom_range(0, 8191)),
                           16'($urandom_range(0, 51472)), 16'($urandom_range(0, 1500)),
                           16'($urandom_range(0, 255)));
            run_random_frames(200, int'(sh_width));
        end
        write_all_regs(16'd640, 16'd1920, 16'd100, 16'd50, 16'd25736, 16'd1000, 16'd10);
        run_random_frames(150, 640);
    endtask

    initial begin
        error_count    = 0;
        frames_sent    = 0;
        presses_seen   = 0;
        releases_seen  = 0;
        idle_cycles    = 0;
        burst_left     = 0;
        no_gaps        = 1'b0;
        hold_req       = 1'b0;
        hold_left      = 0;
        stall_mode     = 0;
        stall_timer    = 0;
        sh_width       = RST_SENSOR_WIDTH;
        sh_baseline    = RST_BASELINE;
        sh_offx        = RST_OFFSET_X;
        sh_offy        = RST_OFFSET_Y;
        sh_fov         = RST_FOV;
        sh_dwell       = RST_DWELL_MS;
        sh_radius      = RST_CLICK_RADIUS;
        tr_held        = 1'b0;
        tr_last_x      = 0;
        tr_last_y      = 0;
        tr_anchor_x    = 0;
        tr_anchor_y    = 0;
        tr_anchor_time = '0;
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = '0;
        i_cfg_data     = '0;
        frame_ch.valid = 1'b0;
        frame_ch.data  = '0;
        touch_ch.ready = 1'b0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(negedge i_clk);

        test_directed_extremes();
        test_back_pressure();
        test_zero_width_and_flat_angle();
        test_register_sweep();

        wait_drained();
        repeat (300) @(posedge i_clk);
        $display("Sent %0d camera frames over twelve register settings and extremes,",
                 frames_sent);
        $display("with %0d presses and %0d releases checked under back-pressure.",
                 presses_seen, releases_seen);
        if (error_count == 0 && expected_touches.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
